// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== rtl/core/bsm_pkg.sv =====
// types, constants and helper functions for the booth multiplier
package bsm_pkg;

	localparam int BYTE_W        = 8;
	localparam int DEF_MAX_BYTES = 4;
	localparam int LEN_W         = 3;
	localparam int BITS_W        = 32;
	localparam int PROD_W        = 64;
	localparam int PBYTES_W      = 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;
	} status_t;

	// zero length counts as one byte, long lengths saturate
	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n,
		input logic [LEN_W-1:0] maxb);
		logic [LEN_W-1:0] r;
		r = n;
		if (n == '0) begin
			r = LEN_W'(1);
		end else if (n > maxb) begin
			r = maxb;
		end
		return r;
	endfunction

	// sign-extend the low len bytes of raw
	function automatic logic [PROD_W-1:0] sext(input logic [BITS_W-1:0] raw,
		input logic [LEN_W-1:0] len);
		logic [PROD_W-1:0] r;
		case (len)
			3'd1: r = {{(PROD_W-8){raw[7]}}, raw[7:0]};
			3'd2: r = {{(PROD_W-16){raw[15]}}, raw[15:0]};
			3'd3: r = {{(PROD_W-24){raw[23]}}, raw[23:0]};
			default: r = {{(PROD_W-32){raw[31]}}, raw[31:0]};
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/bsm_ctrl.sv =====
// controller state machine of the booth multiplier
module bsm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bsm_pkg::status_t status,
	output bsm_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);
	import bsm_pkg::*;

	state_t state_q;
	state_t state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_n = ST_RUN;
			end
			ST_RUN: begin
				if (status.last) state_n = ST_DONE;
			end
			ST_DONE: begin
				state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		busy     = 1'b1;
		done     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_RUN: begin
				cmd.step = 1'b1;
			end
			ST_DONE: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/core/bsm_datapath.sv =====
// booth add-and-shift datapath: operand select, accumulator, step counter
module bsm_datapath #(
	parameter int MAX_BYTES = bsm_pkg::DEF_MAX_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bsm_pkg::cmd_t                  cmd,
	input  logic [bsm_pkg::BITS_W-1:0]     lhs_bits,
	input  logic [bsm_pkg::LEN_W-1:0]      lhs_bytes,
	input  logic [bsm_pkg::BITS_W-1:0]     rhs_bits,
	input  logic [bsm_pkg::LEN_W-1:0]      rhs_bytes,
	output bsm_pkg::status_t               status,
	output logic signed [bsm_pkg::PROD_W-1:0] product,
	output logic [bsm_pkg::PBYTES_W-1:0]   product_bytes
);
	import bsm_pkg::*;

	localparam int OP_W  = BYTE_W * MAX_BYTES;
	localparam int CNT_W = $clog2(OP_W + 1);

	logic [LEN_W-1:0]    llen;
	logic [LEN_W-1:0]    rlen;
	logic [PROD_W-1:0]   lval;
	logic [PROD_W-1:0]   rval;
	logic                swap;
	logic [LEN_W-1:0]    mlen;

	logic [PROD_W-1:0]   acc_q;
	logic [PROD_W-1:0]   mcand_q;
	logic [OP_W-1:0]     mplier_q;
	logic                prev_q;
	logic [CNT_W-1:0]    count_q;
	logic [PBYTES_W-1:0] pbytes_q;
	logic [PROD_W-1:0]   acc_n;

	// operand lengths and sign extension
	always_comb begin
		llen = clamp_len(lhs_bytes, LEN_W'(MAX_BYTES));
		rlen = clamp_len(rhs_bytes, LEN_W'(MAX_BYTES));
		lval = sext(lhs_bits, llen);
		rval = sext(rhs_bits, rlen);
		swap = (rlen > llen);
		mlen = swap ? llen : rlen;
	end

	// booth recode of the current pair: 10 subtracts, 01 adds
	always_comb begin
		acc_n = acc_q;
		if (mplier_q[0] && !prev_q) begin
			acc_n = acc_q - mcand_q;
		end else if (!mplier_q[0] && prev_q) begin
			acc_n = acc_q + mcand_q;
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= CNT_W'(mlen) << 3;
		end else if (cmd.step && count_q != '0) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// operand and accumulator registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q    <= '0;
			prev_q   <= 1'b0;
			mcand_q  <= swap ? rval : lval;
			mplier_q <= swap ? lval[OP_W-1:0] : rval[OP_W-1:0];
			pbytes_q <= PBYTES_W'(llen) + PBYTES_W'(rlen);
		end else if (cmd.step) begin
			acc_q    <= acc_n;
			prev_q   <= mplier_q[0];
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign status.last   = (count_q == CNT_W'(1));
	assign product       = acc_q;
	assign product_bytes = pbytes_q;

endmodule

// ===== rtl/core/booth_signed_multiplier.sv =====
// top level of the radix-2 booth signed multiplier
//
// Command interface: a beat is taken at a rising edge where start is high and
// busy is low. lhs_bits/rhs_bits hold little-endian two's-complement bytes,
// lhs_bytes/rhs_bytes their lengths; a length of zero counts as one byte and
// a length above MAX_BYTES counts as MAX_BYTES. Bytes above the length are
// ignored. The shorter operand (right one on a tie) is the multiplier.
// The result beat (product, product_bytes) is shown for exactly one cycle
// with done high; the receiver cannot stall it and must take it then.
// After the accepting edge the controller runs one add-or-subtract and shift
// per bit of the multiplier (8*m steps, with m its length in bytes) into the
// single 64-bit accumulator, then shows the result in the done state. busy
// stays high until done has been shown. Reset returns the controller to idle;
// no result is pending after reset.
module booth_signed_multiplier #(
	parameter int MAX_BYTES = bsm_pkg::DEF_MAX_BYTES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [bsm_pkg::BITS_W-1:0]        lhs_bits,
	input  logic [bsm_pkg::LEN_W-1:0]         lhs_bytes,
	input  logic [bsm_pkg::BITS_W-1:0]        rhs_bits,
	input  logic [bsm_pkg::LEN_W-1:0]         rhs_bytes,
	output logic                              done,
	output logic signed [bsm_pkg::PROD_W-1:0] product,
	output logic [bsm_pkg::PBYTES_W-1:0]      product_bytes
);
	import bsm_pkg::*;

	`include "assert_macros.svh"

	cmd_t    cmd;
	status_t status;

	// controller
	bsm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath
	bsm_datapath #(
		.MAX_BYTES (MAX_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.lhs_bits      (lhs_bits),
		.lhs_bytes     (lhs_bytes),
		.rhs_bits      (rhs_bits),
		.rhs_bytes     (rhs_bytes),
		.status        (status),
		.product       (product),
		.product_bytes (product_bytes)
	);

	// checks
	`ASSERT_IMPLY(a_done_busy, clk, arst_n, done, busy)
	`ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)
	`ASSERT_IMPLY(a_pbytes_range, clk, arst_n, done,
		(product_bytes >= PBYTES_W'(2)) && (product_bytes <= PBYTES_W'(2 * MAX_BYTES)))

endmodule

// ===== tb/tb.sv =====
// testbench for the radix-2 booth signed multiplier: directed and random operand beats
module tb;
	import bsm_pkg::*;

	localparam int MAXB = DEF_MAX_BYTES;

	typedef struct packed {
		logic signed [PROD_W-1:0] product;
		logic [PBYTES_W-1:0]      nbytes;
	} booth_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [BITS_W-1:0]        lhs_bits;
	logic [LEN_W-1:0]         lhs_bytes;
	logic [BITS_W-1:0]        rhs_bits;
	logic [LEN_W-1:0]         rhs_bytes;
	logic                     done;
	logic signed [PROD_W-1:0] product;
	logic [PBYTES_W-1:0]      product_bytes;

	booth_result_t pending_products[$];
	booth_result_t want;
	int            mismatches;
	bit            idle_en;

	booth_signed_multiplier #(.MAX_BYTES(MAXB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.lhs_bits(lhs_bits),
		.lhs_bytes(lhs_bytes),
		.rhs_bits(rhs_bits),
		.rhs_bytes(rhs_bytes),
		.done(done),
		.product(product),
		.product_bytes(product_bytes)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// effective length: zero counts as one byte, long lengths saturate
	function automatic int eff_len(input logic [LEN_W-1:0] n);
		int r;
		r = int'(n);
		if (r < 1) r = 1;
		if (r > MAXB) r = MAXB;
		return r;
	endfunction

	// widen the low len bytes of raw with its sign bit
	function automatic logic [PROD_W-1:0] widen(input logic [BITS_W-1:0] raw, input int len);
		logic [PROD_W-1:0] mask;
		logic [PROD_W-1:0] v;
		mask = (64'd1 << (BYTE_W * len)) - 64'd1;
		v = {32'd0, raw} & mask;
		if (v[BYTE_W * len - 1]) v = v | ~mask;
		return v;
	endfunction

	// expected product by booth recoding of the shorter operand
	function automatic booth_result_t booth_product(input logic [BITS_W-1:0] lb,
		input logic [LEN_W-1:0] ll, input logic [BITS_W-1:0] rb, input logic [LEN_W-1:0] rl);
		booth_result_t r;
		int            llen;
		int            rlen;
		int            mlen;
		logic [PROD_W-1:0] mcand;
		logic [PROD_W-1:0] mplier;
		logic [PROD_W-1:0] acc;
		logic          prev;
		logic          cur;
		int            i;
		llen = eff_len(ll);
		rlen = eff_len(rl);
		mcand = widen(lb, llen);
		mplier = widen(rb, rlen);
		mlen = rlen;
		// right operand is the multiplier unless it is strictly longer
		if (rlen > llen) begin
			mcand = widen(rb, rlen);
			mplier = widen(lb, llen);
			mlen = llen;
		end
		acc = '0;
		prev = 1'b0;
		for (i = 0; i < BYTE_W * mlen; i++) begin
			cur = mplier[i];
			if (cur && !prev) acc = acc - (mcand << i);
			else if (!cur && prev) acc = acc + (mcand << i);
			prev = cur;
		end
		r.product = acc;
		r.nbytes = PBYTES_W'(llen + rlen);
		return r;
	endfunction

	task automatic report(input string what, input logic [PROD_W-1:0] got,
		input logic [PROD_W-1:0] exp_v);
		$display("mismatch on %s: got %0h, want %0h at %0t", what, got, exp_v, $realtime);
		mismatches++;
	endtask

	// result checker: each done beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_products.size() == 0) begin
				report("unexpected result beat", product, '0);
			end else begin
				want = pending_products.pop_front();
				if (product !== want.product) report("product", product, want.product);
				if (product_bytes !== want.nbytes)
					report("product_bytes", PROD_W'(product_bytes), PROD_W'(want.nbytes));
			end
		end
	end

	// send one operand beat, waiting a random gap first when idling is on
	task automatic send_operands(input logic [BITS_W-1:0] lb, input logic [LEN_W-1:0] ll,
		input logic [BITS_W-1:0] rb, input logic [LEN_W-1:0] rl);
		int gap;
		gap = idle_en ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		lhs_bits <= lb;
		lhs_bytes <= ll;
		rhs_bits <= rb;
		rhs_bytes <= rl;
		// accepted at the first edge with busy low
		do @(posedge clk); while (busy);
		pending_products.push_back(booth_product(lb, ll, rb, rl));
	endtask

	// operand with a random length and a mix of corner and random values
	task automatic random_operand(output logic [BITS_W-1:0] raw, output logic [LEN_W-1:0] len);
		int sel;
		int nb;
		logic [BITS_W-1:0] junk;
		len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 7))
			: LEN_W'($urandom_range(1, MAXB));
		nb = eff_len(len) * BYTE_W;
		junk = $urandom();
		sel = $urandom_range(0, 9);
		case (sel)
			0: raw = '0;
			1: raw = '1;
			// most negative value for the length, junk above it
			2: raw = (nb == BITS_W) ? 32'h8000_0000 : ((junk >> nb) << nb) | (32'd1 << (nb - 1));
			// most positive value for the length, junk above it
			3: raw = (nb == BITS_W) ? 32'h7fff_ffff
				: ((junk >> nb) << nb) | ((32'd1 << (nb - 1)) - 32'd1);
			4: raw = 32'd1;
			default: raw = junk;
		endcase
	endtask

	// extremes of both operands at the shortest, middle and longest lengths
	task automatic test_extremes();
		idle_en = 1'b1;
		send_operands(32'h0000_0080, 3'd1, 32'h0000_0080, 3'd1);
		send_operands(32'h0000_007f, 3'd1, 32'h0000_0080, 3'd1);
		send_operands(32'h8000_0000, 3'd4, 32'h8000_0000, 3'd4);
		send_operands(32'h7fff_ffff, 3'd4, 32'h7fff_ffff, 3'd4);
		send_operands(32'h8000_0000, 3'd4, 32'h7fff_ffff, 3'd4);
		send_operands(32'hffff_ffff, 3'd4, 32'hffff_ffff, 3'd4);
		send_operands(32'h0000_0000, 3'd4, 32'h8000_0000, 3'd4);
		send_operands(32'h8000_0000, 3'd4, 32'h0000_0080, 3'd1);
		send_operands(32'h0000_0080, 3'd1, 32'h8000_0000, 3'd4);
		send_operands(32'h0000_7fff, 3'd2, 32'h0080_0000, 3'd3);
		send_operands(32'h0080_0000, 3'd3, 32'h0000_8000, 3'd2);
		send_operands(32'h5555_5555, 3'd4, 32'haaaa_aaaa, 3'd4);
		send_operands(32'h0000_0001, 3'd1, 32'hffff_ffff, 3'd4);
	endtask

	// zero and oversized lengths, with junk in the ignored upper bytes
	task automatic test_length_clamping();
		idle_en = 1'b0;
		send_operands(32'hdead_be80, 3'd0, 32'h1234_5678, 3'd7);
		send_operands(32'h8000_0000, 3'd5, 32'hffff_ff7f, 3'd0);
		send_operands(32'hcafe_f00d, 3'd6, 32'h8000_0000, 3'd7);
		send_operands(32'hffff_ff01, 3'd0, 32'hffff_ff80, 3'd0);
		send_operands(32'h7fff_ffff, 3'd7, 32'h0000_0000, 3'd6);
		send_operands(32'hff00_8000, 3'd2, 32'h00ff_ff00, 3'd1);
		send_operands(32'h1280_0000, 3'd3, 32'hfe7f_ffff, 3'd3);
	endtask

	// random operands, idling switched in stretches
	task automatic test_random_products(input int count);
		logic [BITS_W-1:0] lb;
		logic [BITS_W-1:0] rb;
		logic [LEN_W-1:0]  ll;
		logic [LEN_W-1:0]  rl;
		int                k;
		for (k = 0; k < count; k++) begin
			if (k % 50 == 0) idle_en = ($urandom_range(0, 2) != 0);
			random_operand(lb, ll);
			random_operand(rb, rl);
			send_operands(lb, ll, rb, rl);
		end
	endtask

	// run limit
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	// main sequence
	initial begin
		mismatches = 0;
		idle_en = 1'b0;
		arst_n = 1'b0;
		start <= 1'b0;
		lhs_bits <= '0;
		lhs_bytes <= 3'd1;
		rhs_bits <= '0;
		rhs_bytes <= 3'd1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_length_clamping();
		test_random_products(1530);
		start <= 1'b0;
		// drain remaining results, then allow one more beat time
		while (pending_products.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bsm_pkg.sv
rtl/core/bsm_ctrl.sv
rtl/core/bsm_datapath.sv
rtl/core/booth_signed_multiplier.sv
tb/tb.sv
